@@ rtl/bba_pkg.sv @@
// Package for the block bitmap allocator.
// Holds the opcode codes, fixed field widths and the word unit control struct.
// Depends on nothing; every other file of the block uses it.
package bba_pkg;

  localparam int WORD_BITS    = 64;
  localparam int OFF_W        = 6;
  localparam int BLOCK_W      = 12;
  localparam int FIELD_BLOCKS = 4096;

  localparam logic [1:0] OP_MARK_USED = 2'd0;
  localparam logic [1:0] OP_MARK_FREE = 2'd1;
  localparam logic [1:0] OP_FIND      = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_FREE = 1'b1;

  typedef struct packed {
    logic             set_bit;
    logic [OFF_W-1:0] bit_off;
    logic             last_word;
  } word_ctrl_t;

endpackage

@@ rtl/bba_in_if.sv @@
// Input channel of the block bitmap allocator: valid, ready and one request.
// Depends on bba_pkg for the field widths.
interface bba_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [bba_pkg::BLOCK_W-1:0]   block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink (input valid, input opcode, input block_number, output ready);
endinterface

@@ rtl/bba_out_if.sv @@
// Result channel of the block bitmap allocator: valid, ready and one result.
// Depends on bba_pkg for the field widths.
interface bba_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [bba_pkg::BLOCK_W-1:0]   free_block;

  modport source (output valid, output status, output free_block, input ready);
  modport sink (input valid, input status, input free_block, output ready);
endinterface

@@ rtl/bba_bitmap_ram.sv @@
// Bitmap word memory: one write port and one read port with registered data.
// Depends on bba_pkg for the word width.
module bba_bitmap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [bba_pkg::WORD_BITS-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [bba_pkg::WORD_BITS-1:0] rd_data
);

  logic [bba_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bba_word_unit.sv @@
// Shared word unit: sets or clears one bit of a bitmap word and finds the
// lowest free block in it. Depends on bba_pkg for widths and word_ctrl_t.
module bba_word_unit #(
  parameter int LAST_BITS = 64
) (
  input  logic [bba_pkg::WORD_BITS-1:0] word_in,
  input  bba_pkg::word_ctrl_t           ctrl,
  output logic [bba_pkg::WORD_BITS-1:0] word_out,
  output logic                          hit,
  output logic [bba_pkg::OFF_W-1:0]     hit_off
);

  logic [bba_pkg::WORD_BITS-1:0] bit_mask;
  logic [bba_pkg::WORD_BITS-1:0] free_vec;

  assign bit_mask = bba_pkg::WORD_BITS'(1) << (6'd63 - ctrl.bit_off);
  assign word_out = ctrl.set_bit ? (word_in | bit_mask) : (word_in & ~bit_mask);

  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
      free_vec[i] = ~word_in[bba_pkg::WORD_BITS-1-i] && (!ctrl.last_word || i < LAST_BITS);
    end
    for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        hit     = 1'b1;
        hit_off = bba_pkg::OFF_W'(i);
      end
    end
  end

endmodule

@@ rtl/block_bitmap_allocator_top.sv @@
// Block bitmap allocator top level: sequencer, bitmap memory and word unit.
// Depends on bba_pkg, bba_in_if, bba_out_if, bba_bitmap_ram and bba_word_unit.
//
// Keeps one used/free bit per block, MSB-first in 64-bit words held in a
// single-port-read memory. After reset a clearing pass writes every word, one
// per cycle, during which no request is taken. Mark used and mark free read,
// modify and write back one word, then load the result; an unused opcode or a
// block outside the disk skips the memory and goes straight to the result. A
// find reads one word per cycle through the memory read port, over the first
// min(BLOCK_COUNT,4096) blocks, and encodes the first free bit. A result
// waits in an output register while the next request is taken.
module block_bitmap_allocator_top #(
  parameter int BLOCK_COUNT     = 4096,
  parameter int RESERVED_BLOCKS = 8
) (
  input logic      clk,
  input logic      rst_n,
  bba_in_if.sink   in_ch,
  bba_out_if.source out_ch
);

  localparam int WORD_COUNT = (BLOCK_COUNT + 63) / 64;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LIMIT      = (BLOCK_COUNT < bba_pkg::FIELD_BLOCKS) ?
                              BLOCK_COUNT : bba_pkg::FIELD_BLOCKS;
  localparam int SCAN_WORDS = (LIMIT + 63) / 64;
  localparam int LAST_BITS  = LIMIT - (SCAN_WORDS - 1) * 64;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);
  localparam logic [WAW-1:0] LAST_SCAN = WAW'(SCAN_WORDS - 1);
  localparam logic [bba_pkg::WORD_BITS-1:0] RESET_WORD0 =
    ~({bba_pkg::WORD_BITS{1'b1}} >> RESERVED_BLOCKS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  op_r, op_nxt;
  logic [bba_pkg::BLOCK_W-1:0] blk_r, blk_nxt;
  logic [WAW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [WAW-1:0]              issue_r, issue_nxt;
  logic [WAW-1:0]              chk_r, chk_nxt;
  logic                        pend_r, pend_nxt;
  logic                        res_status_r, res_status_nxt;
  logic [bba_pkg::BLOCK_W-1:0] res_block_r, res_block_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r, out_status_nxt;
  logic [bba_pkg::BLOCK_W-1:0] out_block_r, out_block_nxt;

  logic                          wr_en;
  logic [WAW-1:0]                wr_addr;
  logic [bba_pkg::WORD_BITS-1:0] wr_data;
  logic                          rd_en;
  logic [WAW-1:0]                rd_addr;
  logic [bba_pkg::WORD_BITS-1:0] rd_data;
  bba_pkg::word_ctrl_t           wctrl;
  logic [bba_pkg::WORD_BITS-1:0] word_new;
  logic                          word_hit;
  logic [bba_pkg::OFF_W-1:0]     word_off;
  logic [WAW-1:0]                blk_word;
  logic                          in_xfer;
  logic                          in_range;

  bba_bitmap_ram #(
    .DEPTH(WORD_COUNT),
    .AW   (WAW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bba_word_unit #(
    .LAST_BITS(LAST_BITS)
  ) u_word (
    .word_in (rd_data),
    .ctrl    (wctrl),
    .word_out(word_new),
    .hit     (word_hit),
    .hit_off (word_off)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign in_range          = 32'(in_ch.block_number) < BLOCK_COUNT;
  assign blk_word          = WAW'(blk_r >> bba_pkg::OFF_W);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.free_block = out_block_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    clr_cnt_nxt    = clr_cnt_r;
    issue_nxt      = issue_r;
    chk_nxt        = chk_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    wr_en          = 1'b0;
    wr_addr        = blk_word;
    wr_data        = word_new;
    rd_en          = 1'b0;
    rd_addr        = blk_word;
    wctrl.set_bit   = (op_r == bba_pkg::OP_MARK_USED);
    wctrl.bit_off   = blk_r[bba_pkg::OFF_W-1:0];
    wctrl.last_word = (chk_r == LAST_SCAN);

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = (clr_cnt_r == '0) ? RESET_WORD0 : '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_ch.opcode;
          blk_nxt        = in_ch.block_number;
          res_status_nxt = bba_pkg::STATUS_OK;
          res_block_nxt  = '0;
          issue_nxt      = '0;
          chk_nxt        = '0;
          pend_nxt       = 1'b0;
          if ((in_ch.opcode == bba_pkg::OP_MARK_USED ||
               in_ch.opcode == bba_pkg::OP_MARK_FREE) && in_range) begin
            state_nxt = ST_READ;
          end else if (in_ch.opcode == bba_pkg::OP_FIND) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_MODIFY;
      end
      ST_MODIFY: begin
        wr_en     = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_SCAN: begin
        rd_en     = 1'b1;
        rd_addr   = issue_r;
        issue_nxt = (issue_r == LAST_SCAN) ? issue_r : issue_r + 1'b1;
        pend_nxt  = 1'b1;
        if (pend_r) begin
          if (word_hit) begin
            res_status_nxt = bba_pkg::STATUS_OK;
            res_block_nxt  = bba_pkg::BLOCK_W'((32'(chk_r) << bba_pkg::OFF_W) | 32'(word_off));
            state_nxt      = ST_RESP;
          end else if (chk_r == LAST_SCAN) begin
            res_status_nxt = bba_pkg::STATUS_NO_FREE;
            res_block_nxt  = '0;
            state_nxt      = ST_RESP;
          end else begin
            chk_nxt = chk_r + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_block_nxt  = res_block_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    issue_r      <= issue_nxt;
    chk_r        <= chk_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !wr_en)
    else $error("bitmap written during a find scan");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside the response state");

  a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == bba_pkg::STATUS_NO_FREE) |-> (out_block_r == '0))
    else $error("no-free result carries a nonzero block number");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> (chk_r <= issue_r))
    else $error("scan check index ran ahead of the read index");

endmodule
